>>> src/sharpen_3x3_cross_filter_top_defines.svh
// assertion macros for the 3x3 cross sharpening filter
// used by sharpen_3x3_cross_filter_top; no other dependencies
`ifndef SHARPEN_3X3_CROSS_FILTER_TOP_DEFINES_SVH
`define SHARPEN_3X3_CROSS_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scf assertion failed");

// next-cycle implication
`define SCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scf assertion failed");

`else

`define SCF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/scf_pkg.sv
// shared constants, types and helper functions of the cross sharpening filter
// no dependencies
package scf_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int SAMPLE_W = 8;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 12;
    localparam int CHCNT_W  = 3;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 11;
    localparam int CHPOS_W  = 2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 12'd480;
    localparam logic [CHCNT_W-1:0]  CHANNELS_RESET = 3'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                run_end;
        logic                frame_end;
    } result_t;

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v < WIDTH_W'(3))
            r = WIDTH_W'(3);
        else if (v > WIDTH_W'(MAX_WIDTH))
            r = WIDTH_W'(MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] v);
        return (v < HEIGHT_W'(3)) ? HEIGHT_W'(3) : v;
    endfunction

    function automatic logic [CHCNT_W-1:0] eff_channels(input logic [CHCNT_W-1:0] v);
        logic [CHCNT_W-1:0] r;
        if (v == CHCNT_W'(0))
            r = CHCNT_W'(1);
        else if (v > CHCNT_W'(MAX_CHANNELS))
            r = CHCNT_W'(MAX_CHANNELS);
        else
            r = v;
        return r;
    endfunction

    // 5*centre - up - left - right - below, clamped to 0..255
    function automatic logic [SAMPLE_W-1:0] sharpen(
        input logic [SAMPLE_W-1:0] centre,
        input logic [SAMPLE_W-1:0] up,
        input logic [SAMPLE_W-1:0] left,
        input logic [SAMPLE_W-1:0] right,
        input logic [SAMPLE_W-1:0] below
    );
        logic [SAMPLE_W+2:0] five_c;
        logic [SAMPLE_W+1:0] sum4;
        logic [SAMPLE_W+2:0] diff;
        logic [SAMPLE_W-1:0] r;
        five_c = (SAMPLE_W+3)'({centre, 2'b00}) + (SAMPLE_W+3)'(centre);
        sum4   = (SAMPLE_W+2)'(up) + (SAMPLE_W+2)'(left)
               + (SAMPLE_W+2)'(right) + (SAMPLE_W+2)'(below);
        diff   = five_c - (SAMPLE_W+3)'(sum4);
        if (five_c < (SAMPLE_W+3)'(sum4))
            r = '0;
        else if (diff > (SAMPLE_W+3)'(255))
            r = '1;
        else
            r = diff[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

>>> src/sharpen_3x3_cross_filter_top.sv
// top level of the 3x3 cross sharpening filter: line stores, filter, result queue
// depends on scf_pkg and sharpen_3x3_cross_filter_top_defines.svh
//
// usage
// - input stream (s_*): one 8-bit sample per request in raster order, channels of a
//   pixel interleaved; s_tuser high marks the first sample of a frame and restarts
//   the row, column and channel counters
// - output stream (m_*): sharpened samples in raster order, one row behind the input;
//   m_tlast marks the last result caused by an input, m_tuser the frame's last result
// - first input row yields nothing; every later row yields one result per input, and
//   the last input row yields two (the computed row above, then the zero border row)
// - apb port: image_width at 0x0, image_height at 0x4, channel_count at 0x8; write
//   only while the block is idle; pready is tied high
// - path: an input is registered in the filter stage, then its result in the queue
// - throughput: one input per cycle while each input yields at most one result and
//   m_tready stays high; the last row is held back by the single output per cycle
// - line stores: two 8192 x 8 synchronous memories; the near store has two read ports
//   (centre and right neighbor), the far store one; reads issue at the accept edge and
//   the write back follows in the next cycle, with forwarding for back-to-back hits
// - reset: counters, left window, result queue and config registers cleared to their
//   defaults; line store contents are undefined until a frame has written them
// - stall: results sit in a four-entry queue; s_tready drops when the queue plus the
//   item in flight could no longer take two more results, so nothing is lost

`include "sharpen_3x3_cross_filter_top_defines.svh"

module sharpen_3x3_cross_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scf_pkg::SAMPLE_W-1:0]   s_tdata,   // [7:0] sample_value
    input  logic                           s_tuser,   // [0] frame_start
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scf_pkg::SAMPLE_W-1:0]   m_tdata,   // [7:0] filtered_value
    output logic                           m_tlast,   // run_end
    output logic                           m_tuser,   // [0] frame_end
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scf_pkg::PADDR_W-1:0]    paddr,
    input  logic [scf_pkg::PDATA_W-1:0]    pwdata,
    output logic [scf_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import scf_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [CHCNT_W-1:0]  channel_count_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= WIDTH_RESET;
            image_height_reg  <= HEIGHT_RESET;
            channel_count_reg <= CHANNELS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[HEIGHT_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = PDATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = PDATA_W'(image_height_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // position counters and address generation (accept stage)
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CHPOS_W-1:0] chpos_reg, chpos_next;

    logic [ROW_W-1:0]    row_cur;
    logic [COL_W-1:0]    col_cur;
    logic [CHPOS_W-1:0]  chpos_cur;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [CHCNT_W-1:0]  ch_eff;
    logic                last_col, last_row, last_ch, last_item, interior;
    logic [1:0]          nres;
    logic [ADDR_W-1:0]   idx, idx_right;
    logic                accept;

    assign accept = s_tvalid && s_tready;

    // a frame start restarts the counters for this very sample
    assign row_cur   = s_tuser ? '0 : row_reg;
    assign col_cur   = s_tuser ? '0 : col_reg;
    assign chpos_cur = s_tuser ? '0 : chpos_reg;

    assign w_eff  = eff_width(image_width_reg);
    assign h_eff  = eff_height(image_height_reg);
    assign ch_eff = eff_channels(channel_count_reg);

    // positions past the limits (config changed mid frame) count as last
    assign last_col  = WIDTH_W'(col_cur) >= (w_eff - WIDTH_W'(1));
    assign last_row  = row_cur >= (h_eff - HEIGHT_W'(1));
    assign last_ch   = CHCNT_W'(chpos_cur) >= (ch_eff - CHCNT_W'(1));
    assign last_item = last_row && last_col && last_ch;
    assign interior  = (row_cur >= ROW_W'(2)) && (col_cur != '0) && !last_col;

    // results caused: none on the first row, two on the last row
    always_comb
    begin
        if (row_cur == '0)
            nres = 2'd0;
        else if (last_row)
            nres = 2'd2;
        else
            nres = 2'd1;
    end

    assign idx       = ADDR_W'(col_cur) * ADDR_W'(ch_eff) + ADDR_W'(chpos_cur);
    assign idx_right = idx + ADDR_W'(ch_eff);

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        chpos_next = chpos_reg;
        if (accept)
        begin
            if (last_ch)
            begin
                chpos_next = '0;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = last_row ? '0 : row_cur + ROW_W'(1);
                end
                else
                begin
                    col_next = col_cur + COL_W'(1);
                    row_next = row_cur;
                end
            end
            else
            begin
                chpos_next = chpos_cur + CHPOS_W'(1);
                col_next   = col_cur;
                row_next   = row_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // filter stage registers
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [CHPOS_W-1:0]  s1_kk_reg;
    logic                s1_interior_reg;
    logic                s1_last_row_reg;
    logic                s1_last_item_reg;
    logic [1:0]          s1_nres_reg;

    // forwarding from the item in the filter stage, whose write lands on the read edge
    logic                fwd_c_reg, fwd_c_next;
    logic                fwd_r_reg, fwd_r_next;
    logic [SAMPLE_W-1:0] fwd_near_reg;
    logic [SAMPLE_W-1:0] fwd_far_reg;

    logic [SAMPLE_W-1:0] rd_centre_reg;
    logic [SAMPLE_W-1:0] rd_right_reg;
    logic [SAMPLE_W-1:0] rd_up_reg;

    logic [SAMPLE_W-1:0] centre, up, right, left, filt;
    logic [SAMPLE_W-1:0] left_window_reg [MAX_CHANNELS];

    assign fwd_c_next = s1_valid_reg && (s1_idx_reg == idx);
    assign fwd_r_next = s1_valid_reg && (s1_idx_reg == idx_right);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            chpos_reg    <= '0;
            s1_valid_reg <= 1'b0;
            fwd_c_reg    <= 1'b0;
            fwd_r_reg    <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            chpos_reg    <= chpos_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                fwd_c_reg <= fwd_c_next;
                fwd_r_reg <= fwd_r_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg       <= idx;
            s1_sample_reg    <= s_tdata;
            s1_kk_reg        <= chpos_cur;
            s1_interior_reg  <= interior;
            s1_last_row_reg  <= last_row;
            s1_last_item_reg <= last_item;
            s1_nres_reg      <= nres;
            fwd_near_reg     <= s1_sample_reg;
            fwd_far_reg      <= centre;
        end
    end

    // ------------------------------------------------------------------
    // line stores
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] near_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] far_mem  [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            near_mem[s1_idx_reg] <= s1_sample_reg;
        if (accept)
        begin
            rd_centre_reg <= near_mem[idx];
            rd_right_reg  <= near_mem[idx_right];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            far_mem[s1_idx_reg] <= centre;
        if (accept)
            rd_up_reg <= far_mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                left_window_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            left_window_reg[s1_kk_reg] <= centre;
        end
    end

    assign centre = fwd_c_reg ? fwd_near_reg : rd_centre_reg;
    assign up     = fwd_c_reg ? fwd_far_reg  : rd_up_reg;
    assign right  = fwd_r_reg ? fwd_near_reg : rd_right_reg;
    assign left   = left_window_reg[s1_kk_reg];
    assign filt   = s1_interior_reg ? sharpen(centre, up, left, right, s1_sample_reg) : '0;

    // ------------------------------------------------------------------
    // result queue, up to two pushes and one pop per cycle
    // ------------------------------------------------------------------
    result_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;
    result_t               entry0, entry1, head;

    assign push_n = s1_valid_reg ? s1_nres_reg : 2'd0;
    assign pop    = m_tvalid && m_tready;

    assign entry0 = '{value: filt, run_end: !s1_last_row_reg, frame_end: 1'b0};
    assign entry1 = '{value: '0, run_end: 1'b1, frame_end: s1_last_item_reg};

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

    // room for the item in flight and two more results
    assign s_tready = (count_reg + FIFO_CNT_W'(push_n)) <= FIFO_CNT_W'(FIFO_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= entry0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= entry1;
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = head.value;
    assign m_tlast  = head.run_end;
    assign m_tuser  = head.frame_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SCF_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `SCF_ASSERT_NOW(a_push_fits, clk, rst_n, s1_valid_reg,
                    (count_reg + FIFO_CNT_W'(s1_nres_reg)) <= FIFO_CNT_W'(FIFO_DEPTH))
    `SCF_ASSERT_NEXT(a_accept_enters_filter, clk, rst_n, accept, s1_valid_reg)
    `SCF_ASSERT_NEXT(a_fwd_needs_writer, clk, rst_n, accept && !s1_valid_reg,
                     !fwd_c_reg && !fwd_r_reg)
    `SCF_ASSERT_NOW(a_frame_end_is_run_end, clk, rst_n, m_tvalid && m_tuser, m_tlast)

endmodule
